FILE: hdl/pbts_pkg.sv
//------------------------------------------------------------------------------
// pbts_pkg
// Shared types and constants for the priority bitmap task scheduler.
//------------------------------------------------------------------------------
package pbts_pkg;

    localparam int TASKS_DEF       = 16;
    localparam int PRIO_LEVELS_DEF = 32;
    localparam int TASK_W          = 4;
    localparam int PRIO_W          = 5;
    localparam int DELAY_W         = 16;
    localparam int SLICE_W         = 8;
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

    // request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_READY    = 3'd1;
    localparam logic [2:0] REQ_UNREADY  = 3'd2;
    localparam logic [2:0] REQ_DELAY    = 3'd3;
    localparam logic [2:0] REQ_WAKE     = 3'd4;
    localparam logic [2:0] REQ_LOCK     = 3'd5;
    localparam logic [2:0] REQ_UNLOCK   = 3'd6;
    localparam logic [2:0] REQ_SCHEDULE = 3'd7;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [TASK_W-1:0]  task_id;
        logic [PRIO_W-1:0]  task_priority;
        logic [DELAY_W-1:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic              switch_now;
        logic [TASK_W-1:0] next_task;
        logic [5:0]        highest_priority;
        logic [4:0]        woken_count;
        logic              status;
    } rsp_t;

endpackage

FILE: hdl/pbts_ram.sv
//------------------------------------------------------------------------------
// pbts_ram
// Generic single-port-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module pbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/priority_bitmap_task_scheduler.sv
//------------------------------------------------------------------------------
// priority_bitmap_task_scheduler
// RTOS scheduler: ready lists per priority in a slot RAM, delay list walk,
// time slice rotation, lock depth and highest-priority selection.
//------------------------------------------------------------------------------
// sequence: a request is registered and dispatched, a schedule adds a head read
//   and check; searching or shifting a ready list goes slot by slot, a tick
//   walks each delayed task plus a list edit per woken task
// throughput: one transaction in flight; the result register frees the input
//   side, so the next input is taken while a result waits
// reset: counters, bitmap, flags and lock clear, slices reload to 10, no task running
module priority_bitmap_task_scheduler #(
    parameter int TASKS       = pbts_pkg::TASKS_DEF,
    parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pbts_pkg::req_t        in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pbts_pkg::rsp_t        out_data,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata
);

    localparam int TW  = $clog2(TASKS);
    localparam int PW  = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int CW  = $clog2(TASKS + 1);
    localparam int SAW = PW + TW;
    localparam int SDEPTH = PRIO_LEVELS * (2 ** TW);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_FIND_RD, S_FIND_CHK, S_REM_RD, S_REM_WR,
        S_ADD_RD, S_ADD_WR, S_ADD_HEAD, S_DREM, S_TICK_RD, S_TICK_CHK,
        S_TICK_ADD, S_SLICE, S_ROT_WR, S_SCHED_RD, S_SCHED_CHK, S_HEAD_RD,
        S_HEAD_CHK, S_OUT
    } state_t;

    // which operation follows a find/remove/add sub-sequence
    typedef enum logic [2:0] {
        K_READY, K_UNREADY, K_TICKWAKE, K_ROTATE, K_NONE
    } cont_t;

    state_t state_reg;
    cont_t  cont_reg;
    pbts_pkg::req_t req_reg;
    pbts_pkg::rsp_t rsp_reg;
    logic rsp_valid_reg;

    logic [7:0] slice_reload_reg;
    logic [PW-1:0]      prio_reg  [TASKS];
    logic [15:0]        dleft_reg [TASKS];
    logic [TASKS-1:0]   dflag_reg;
    logic [7:0]         slice_reg [TASKS];
    logic [CW-1:0]      rcount_reg[PRIO_LEVELS];
    logic [PRIO_LEVELS-1:0] bitmap_reg;
    logic [TW-1:0]      dorder_reg[TASKS];
    logic [CW-1:0]      dcount_reg;
    logic [TW:0]        running_reg;
    logic [7:0]         lock_reg;

    // work registers
    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] at_reg;
    logic [CW-1:0] walk_reg;
    logic [4:0]    woken_reg;
    logic          sw_reg;
    logic          rej_reg;
    logic          found_reg;

    // slot ram
    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [TW-1:0]  s_wdata, s_rdata;

    pbts_ram #(.WIDTH(TW), .DEPTH(SDEPTH)) u_slots (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    function automatic logic [SAW-1:0] sa(input logic [PW-1:0] p, input logic [CW-1:0] i);
        sa = {p, i[TW-1:0]};
    endfunction

    // lowest set bitmap bit
    logic [PW:0] top_p;
    always_comb
    begin
        top_p = (PW+1)'(PRIO_LEVELS);
        for (int k = PRIO_LEVELS - 1; k >= 0; k--)
        begin
            if (bitmap_reg[k])
            begin
                top_p = (PW+1)'(k);
            end
        end
    end

    logic id_ok;
    assign id_ok = 32'(req_reg.task_id) < TASKS;
    logic [TW-1:0] req_t_id;
    assign req_t_id = TW'(req_reg.task_id);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

    // ram port control
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = sa(p_reg, i_reg);
        s_wdata = s_rdata;
        s_raddr = sa(p_reg, i_reg);
        case (state_reg)
            S_REM_RD:   s_raddr = sa(p_reg, i_reg + 1'b1);
            S_REM_WR:   begin s_we = 1'b1; s_waddr = sa(p_reg, i_reg); end
            S_ADD_RD:   s_raddr = sa(p_reg, i_reg - 1'b1);
            S_ADD_WR:   begin s_we = 1'b1; s_waddr = sa(p_reg, i_reg); end
            S_ADD_HEAD: begin s_we = 1'b1; s_waddr = sa(p_reg, '0); s_wdata = t_reg; end
            S_ROT_WR:   begin s_we = 1'b1; s_waddr = sa(p_reg, i_reg); s_wdata = t_reg; end
            S_SCHED_RD, S_HEAD_RD, S_HEAD_CHK: s_raddr = sa(top_p[PW-1:0], '0);
            default: ;
        endcase
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cont_reg         <= K_NONE;
            rsp_valid_reg    <= 1'b0;
            slice_reload_reg <= pbts_pkg::SLICE_RESET;
            dflag_reg        <= '0;
            bitmap_reg       <= '0;
            dcount_reg       <= '0;
            running_reg      <= (TW+1)'(TASKS);
            lock_reg         <= '0;
            for (int k = 0; k < TASKS; k++)
            begin
                prio_reg[k]  <= '0;
                dleft_reg[k] <= '0;
                slice_reg[k] <= pbts_pkg::SLICE_RESET;
            end
            for (int k = 0; k < PRIO_LEVELS; k++)
            begin
                rcount_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                slice_reload_reg <= cfg_wdata;
            end
            if (out_valid && out_ready && state_reg != S_HEAD_CHK)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        req_reg   <= in_data;
                        sw_reg    <= 1'b0;
                        rej_reg   <= 1'b0;
                        woken_reg <= '0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    state_reg <= S_OUT;
                    case (req_reg.req_type)
                        pbts_pkg::REQ_TICK:
                        begin
                            i_reg <= '0;
                            n_reg <= '0;
                            state_reg <= S_TICK_RD;
                        end
                        pbts_pkg::REQ_READY, pbts_pkg::REQ_UNREADY:
                        begin
                            if (!id_ok)
                            begin
                                rej_reg <= 1'b1;
                            end
                            else
                            begin
                                t_reg <= req_t_id;
                                p_reg <= prio_reg[req_t_id];
                                i_reg <= '0;
                                cont_reg <= (req_reg.req_type == pbts_pkg::REQ_READY) ?
                                            K_READY : K_UNREADY;
                                state_reg <= S_FIND_RD;
                            end
                        end
                        pbts_pkg::REQ_DELAY:
                        begin
                            if (!id_ok || req_reg.delay_ticks == '0)
                            begin
                                rej_reg <= 1'b1;
                            end
                            else
                            begin
                                t_reg <= req_t_id;
                                i_reg <= '0;
                                n_reg <= '0;
                                state_reg <= S_DREM;
                            end
                        end
                        pbts_pkg::REQ_WAKE:
                        begin
                            if (!id_ok || !dflag_reg[req_t_id])
                            begin
                                rej_reg <= 1'b1;
                            end
                            else
                            begin
                                t_reg <= req_t_id;
                                i_reg <= '0;
                                n_reg <= '0;
                                state_reg <= S_DREM;
                            end
                        end
                        pbts_pkg::REQ_LOCK:
                        begin
                            if (lock_reg != pbts_pkg::LOCK_MAX)
                            begin
                                lock_reg <= lock_reg + 8'd1;
                            end
                        end
                        pbts_pkg::REQ_UNLOCK:
                        begin
                            if (lock_reg != '0)
                            begin
                                lock_reg <= lock_reg - 8'd1;
                                if (lock_reg == 8'd1)
                                begin
                                    state_reg <= S_SCHED_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= S_SCHED_RD;
                        end
                    endcase
                end
                // linear search of the level for t
                S_FIND_RD:
                begin
                    if (i_reg >= rcount_reg[p_reg])
                    begin
                        found_reg <= 1'b0;
                        state_reg <= S_REM_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIND_CHK;
                    end
                end
                S_FIND_CHK:
                begin
                    if (s_rdata == t_reg)
                    begin
                        found_reg <= 1'b1;
                        at_reg    <= i_reg;
                        state_reg <= S_REM_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_FIND_RD;
                    end
                end
                // close the gap: slot[i] <= slot[i+1]
                S_REM_RD:
                begin
                    if (!found_reg)
                    begin
                        // not in list: reject an unready, else carry on
                        if (cont_reg == K_UNREADY)
                        begin
                            rej_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else if (cont_reg == K_ROTATE)
                        begin
                            state_reg <= S_SLICE;
                        end
                        else
                        begin
                            if (cont_reg == K_READY)
                            begin
                                p_reg <= (32'(req_reg.task_priority) < PRIO_LEVELS) ?
                                         req_reg.task_priority[PW-1:0] : PW'(PRIO_LEVELS - 1);
                                prio_reg[t_reg] <= (32'(req_reg.task_priority) < PRIO_LEVELS) ?
                                         req_reg.task_priority[PW-1:0] : PW'(PRIO_LEVELS - 1);
                            end
                            state_reg <= S_ADD_RD;
                            i_reg <= (cont_reg == K_READY) ?
                                     rcount_reg[(32'(req_reg.task_priority) < PRIO_LEVELS) ?
                                     req_reg.task_priority[PW-1:0] : PW'(PRIO_LEVELS - 1)] :
                                     rcount_reg[p_reg];
                        end
                    end
                    else if (at_reg + 1'b1 >= rcount_reg[p_reg])
                    begin
                        // gap closed
                        rcount_reg[p_reg] <= rcount_reg[p_reg] - 1'b1;
                        if (rcount_reg[p_reg] == CW'(1))
                        begin
                            bitmap_reg[p_reg] <= 1'b0;
                        end
                        found_reg <= 1'b0;
                        if (cont_reg == K_UNREADY)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (cont_reg == K_ROTATE)
                        begin
                            i_reg <= rcount_reg[p_reg] - 1'b1;
                            state_reg <= S_ROT_WR;
                        end
                        else
                        begin
                            if (cont_reg == K_READY)
                            begin
                                p_reg <= (32'(req_reg.task_priority) < PRIO_LEVELS) ?
                                         req_reg.task_priority[PW-1:0] : PW'(PRIO_LEVELS - 1);
                                prio_reg[t_reg] <= (32'(req_reg.task_priority) < PRIO_LEVELS) ?
                                         req_reg.task_priority[PW-1:0] : PW'(PRIO_LEVELS - 1);
                                // count update is registered; re-enter to read it fresh
                                state_reg <= S_REM_RD;
                                cont_reg  <= K_NONE;
                            end
                            else
                            begin
                                state_reg <= S_REM_RD;
                                cont_reg  <= K_NONE;
                            end
                        end
                    end
                    else
                    begin
                        i_reg     <= at_reg;
                        state_reg <= S_REM_WR;
                    end
                end
                S_REM_WR:
                begin
                    at_reg    <= at_reg + 1'b1;
                    i_reg     <= at_reg + 1'b1;
                    state_reg <= S_REM_RD;
                end
                // open the head: slot[i] <= slot[i-1], i from count down to 1
                S_ADD_RD:
                begin
                    if (i_reg == '0)
                    begin
                        state_reg <= S_ADD_HEAD;
                    end
                    else
                    begin
                        state_reg <= S_ADD_WR;
                    end
                end
                S_ADD_WR:
                begin
                    i_reg     <= i_reg - 1'b1;
                    state_reg <= S_ADD_RD;
                end
                S_ADD_HEAD:
                begin
                    rcount_reg[p_reg] <= rcount_reg[p_reg] + 1'b1;
                    bitmap_reg[p_reg] <= 1'b1;
                    if (req_reg.req_type == pbts_pkg::REQ_TICK)
                    begin
                        i_reg     <= walk_reg;
                        state_reg <= S_TICK_RD;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                // drop t from the delay order, compacting in place
                S_DREM:
                begin
                    if (i_reg >= dcount_reg)
                    begin
                        if (req_reg.req_type == pbts_pkg::REQ_DELAY)
                        begin
                            dleft_reg[t_reg]  <= req_reg.delay_ticks;
                            dorder_reg[n_reg[TW-1:0]] <= t_reg;
                            dcount_reg        <= n_reg + 1'b1;
                            dflag_reg[t_reg]  <= 1'b1;
                        end
                        else
                        begin
                            dcount_reg       <= n_reg;
                            dflag_reg[t_reg] <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (dorder_reg[i_reg[TW-1:0]] != t_reg)
                        begin
                            dorder_reg[n_reg[TW-1:0]] <= dorder_reg[i_reg[TW-1:0]];
                            n_reg <= n_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end
                // tick walk over the delay order
                S_TICK_RD:
                begin
                    if (i_reg >= dcount_reg)
                    begin
                        dcount_reg <= n_reg;
                        state_reg  <= S_SLICE;
                    end
                    else
                    begin
                        state_reg <= S_TICK_CHK;
                    end
                end
                S_TICK_CHK:
                begin
                    t_reg <= dorder_reg[i_reg[TW-1:0]];
                    if (dleft_reg[dorder_reg[i_reg[TW-1:0]]] <= 16'd1)
                    begin
                        dleft_reg[dorder_reg[i_reg[TW-1:0]]] <= '0;
                        dflag_reg[dorder_reg[i_reg[TW-1:0]]] <= 1'b0;
                        woken_reg <= woken_reg + 5'd1;
                        state_reg <= S_TICK_ADD;
                    end
                    else
                    begin
                        dleft_reg[dorder_reg[i_reg[TW-1:0]]] <=
                            dleft_reg[dorder_reg[i_reg[TW-1:0]]] - 16'd1;
                        dorder_reg[n_reg[TW-1:0]] <= dorder_reg[i_reg[TW-1:0]];
                        n_reg     <= n_reg + 1'b1;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_TICK_RD;
                    end
                end
                S_TICK_ADD:
                begin
                    // save walk position, then head-insert via remove/add
                    walk_reg  <= i_reg + 1'b1;
                    p_reg     <= prio_reg[t_reg];
                    i_reg     <= '0;
                    cont_reg  <= K_TICKWAKE;
                    state_reg <= S_FIND_RD;
                end
                // slice handling of the running task
                S_SLICE:
                begin
                    state_reg <= S_SCHED_RD;
                    if (cont_reg == K_ROTATE)
                    begin
                        slice_reg[running_reg[TW-1:0]] <= slice_reload_reg;
                        cont_reg <= K_NONE;
                    end
                    else if (32'(running_reg) < TASKS)
                    begin
                        if (slice_reg[running_reg[TW-1:0]] <= 8'd1)
                        begin
                            if (rcount_reg[prio_reg[running_reg[TW-1:0]]] > CW'(1))
                            begin
                                t_reg     <= running_reg[TW-1:0];
                                p_reg     <= prio_reg[running_reg[TW-1:0]];
                                i_reg     <= '0;
                                cont_reg  <= K_ROTATE;
                                state_reg <= S_FIND_RD;
                            end
                            else
                            begin
                                slice_reg[running_reg[TW-1:0]] <= slice_reload_reg;
                            end
                        end
                        else
                        begin
                            slice_reg[running_reg[TW-1:0]] <=
                                slice_reg[running_reg[TW-1:0]] - 8'd1;
                        end
                    end
                end
                S_ROT_WR:
                begin
                    rcount_reg[p_reg] <= rcount_reg[p_reg] + 1'b1;
                    bitmap_reg[p_reg] <= 1'b1;
                    state_reg <= S_SLICE;
                end
                // pick head of highest level
                S_SCHED_RD:
                begin
                    state_reg <= S_SCHED_CHK;
                end
                S_SCHED_CHK:
                begin
                    if (lock_reg == '0 && 32'(top_p) < PRIO_LEVELS &&
                        {1'b0, s_rdata} != running_reg)
                    begin
                        running_reg <= {1'b0, s_rdata};
                        sw_reg      <= 1'b1;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_HEAD_RD;
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CHK;
                end
                // load the result register once the previous result is taken
                S_HEAD_CHK:
                begin
                    if (!rsp_valid_reg || out_ready)
                    begin
                        rsp_reg.switch_now       <= sw_reg;
                        rsp_reg.next_task        <= (32'(top_p) < PRIO_LEVELS) ?
                                                    pbts_pkg::TASK_W'(s_rdata) : '0;
                        rsp_reg.highest_priority <= 6'(top_p);
                        rsp_reg.woken_count      <= woken_reg;
                        rsp_reg.status           <= rej_reg;
                        rsp_valid_reg            <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // tick wake continuation after head insert is set in S_ADD_HEAD;
            // ready continuation clears found path via K_NONE
            if (state_reg == S_REM_RD && found_reg == 1'b0 && cont_reg == K_NONE)
            begin
                state_reg <= S_ADD_RD;
                i_reg     <= rcount_reg[p_reg];
            end
        end
    end

    // assertions
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_dcount: assert property (@(posedge clk) disable iff (!rst_n)
        32'(dcount_reg) <= TASKS)
        else $error("delay count overflow");
    a_sw_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HEAD_CHK && sw_reg |-> lock_reg == '0)
        else $error("switch while locked");

endmodule

FILE: verif/priority_bitmap_task_scheduler_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// priority_bitmap_task_scheduler_tb
// Drives scheduler requests with random idling and back pressure, predicts
// every response from a behavioral copy of the ready lists, delay list,
// slices and lock depth, and compares each response field by field.
//------------------------------------------------------------------------------
module priority_bitmap_task_scheduler_tb;

    localparam int NT = 16;
    localparam int NP = 32;

    // scheduler state mirror and expected response store
    class sched_scoreboard;
        logic [7:0]  slice_len;
        logic [4:0]  prio_of [NT];
        logic [15:0] delay_left [NT];
        bit          delayed [NT];
        logic [7:0]  slice_left [NT];
        int          lvl [NP][$];
        int          delay_q [$];
        int          running;
        int          locks;
        pbts_pkg::rsp_t pending_rsp [$];
        int          errors;
        int          checked;
        int          switches;
        int          wakes;

        function new();
            slice_len = pbts_pkg::SLICE_RESET;
            for (int i = 0; i < NT; i++)
            begin
                prio_of[i] = 0;
                delay_left[i] = 0;
                delayed[i] = 0;
                slice_left[i] = pbts_pkg::SLICE_RESET;
            end
            running = NT;
            locks = 0;
            errors = 0;
            checked = 0;
            switches = 0;
            wakes = 0;
        endfunction

        function int find_in(int p, int t);
            for (int i = 0; i < lvl[p].size(); i++)
                if (lvl[p][i] == t) return i;
            return -1;
        endfunction

        function bit unlink(int t);
            int at;
            at = find_in(prio_of[t], t);
            if (at < 0) return 0;
            lvl[prio_of[t]].delete(at);
            return 1;
        endfunction

        function void push_head(int t);
            void'(unlink(t));
            lvl[prio_of[t]].push_front(t);
        endfunction

        function int top_prio();
            for (int p = 0; p < NP; p++)
                if (lvl[p].size() != 0) return p;
            return NP;
        endfunction

        function bit pick_next();
            int p;
            p = top_prio();
            if (locks > 0 || p >= NP) return 0;
            if (lvl[p][0] == running) return 0;
            running = lvl[p][0];
            return 1;
        endfunction

        function int do_tick();
            int kept [$];
            int woke;
            int r;
            int p;
            woke = 0;
            foreach (delay_q[i])
            begin
                if (delay_left[delay_q[i]] <= 1)
                begin
                    delay_left[delay_q[i]] = 0;
                    delayed[delay_q[i]] = 0;
                    push_head(delay_q[i]);
                    woke++;
                end
                else
                begin
                    delay_left[delay_q[i]]--;
                    kept.push_back(delay_q[i]);
                end
            end
            delay_q = kept;
            if (running < NT)
            begin
                r = running;
                if (slice_left[r] <= 1)
                begin
                    p = prio_of[r];
                    if (lvl[p].size() > 1 && find_in(p, r) >= 0)
                    begin
                        void'(unlink(r));
                        lvl[p].push_back(r);
                    end
                    slice_left[r] = slice_len;
                end
                else
                    slice_left[r]--;
            end
            return woke;
        endfunction

        function void drop_delay(int t);
            int at [$];
            at = delay_q.find_first_index(x) with (x == t);
            if (at.size() != 0) delay_q.delete(at[0]);
        endfunction

        // note an accepted request transaction and queue its response
        function void note_request(pbts_pkg::req_t rq);
            pbts_pkg::rsp_t rs;
            int t;
            int p;
            bit sw;
            bit rej;
            int woke;
            t = rq.task_id;
            sw = 0;
            rej = 0;
            woke = 0;
            case (rq.req_type)
                pbts_pkg::REQ_TICK:
                begin
                    woke = do_tick();
                    sw = pick_next();
                end
                pbts_pkg::REQ_READY:
                begin
                    void'(unlink(t));
                    prio_of[t] = rq.task_priority;
                    push_head(t);
                end
                pbts_pkg::REQ_UNREADY: rej = !unlink(t);
                pbts_pkg::REQ_DELAY:
                begin
                    if (rq.delay_ticks == 0)
                        rej = 1;
                    else
                    begin
                        drop_delay(t);
                        delay_left[t] = rq.delay_ticks;
                        delay_q.push_back(t);
                        delayed[t] = 1;
                    end
                end
                pbts_pkg::REQ_WAKE:
                begin
                    if (!delayed[t])
                        rej = 1;
                    else
                    begin
                        drop_delay(t);
                        delayed[t] = 0;
                    end
                end
                pbts_pkg::REQ_LOCK: if (locks < pbts_pkg::LOCK_MAX) locks++;
                pbts_pkg::REQ_UNLOCK:
                begin
                    if (locks > 0)
                    begin
                        locks--;
                        if (locks == 0) sw = pick_next();
                    end
                end
                default: sw = pick_next();
            endcase
            p = top_prio();
            rs.switch_now = sw;
            rs.next_task = (p < NP) ? pbts_pkg::TASK_W'(lvl[p][0]) : '0;
            rs.highest_priority = 6'(p);
            rs.woken_count = 5'(woke);
            rs.status = rej;
            switches += sw;
            wakes += woke;
            pending_rsp.push_back(rs);
        endfunction

        // compare one response transaction with the oldest expectation
        function void check_response(pbts_pkg::rsp_t got);
            pbts_pkg::rsp_t exp_rsp;
            checked++;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected response %p", got);
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.switch_now !== exp_rsp.switch_now || got.next_task !== exp_rsp.next_task
                || got.highest_priority !== exp_rsp.highest_priority
                || got.woken_count !== exp_rsp.woken_count || got.status !== exp_rsp.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: expected %p got %p", checked, exp_rsp, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    pbts_pkg::req_t in_data;
    logic out_valid;
    logic out_ready;
    pbts_pkg::rsp_t out_data;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    sched_scoreboard sb;
    bit sender_idle_on;
    bit sink_idle_on;
    bit long_hold;
    int sent;

    priority_bitmap_task_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // send one request, with an optional idle burst before it
    task automatic send_req(pbts_pkg::req_t rq);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(rq);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_slice(logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.slice_len = v;
    endtask

    function automatic pbts_pkg::req_t make_req(logic [2:0] k, int t, int p, int d);
        pbts_pkg::req_t r;
        r.req_type = k;
        r.task_id = pbts_pkg::TASK_W'(t);
        r.task_priority = pbts_pkg::PRIO_W'(p);
        r.delay_ticks = pbts_pkg::DELAY_W'(d);
        return r;
    endfunction

    // random request, weighted toward ticks, ready and delay traffic
    function automatic pbts_pkg::req_t rand_req();
        int w;
        logic [2:0] k;
        int d;
        w = $urandom_range(0, 99);
        if (w < 30) k = pbts_pkg::REQ_TICK;
        else if (w < 50) k = pbts_pkg::REQ_READY;
        else if (w < 60) k = pbts_pkg::REQ_UNREADY;
        else if (w < 72) k = pbts_pkg::REQ_DELAY;
        else if (w < 78) k = pbts_pkg::REQ_WAKE;
        else if (w < 84) k = pbts_pkg::REQ_LOCK;
        else if (w < 92) k = pbts_pkg::REQ_UNLOCK;
        else k = pbts_pkg::REQ_SCHEDULE;
        w = $urandom_range(0, 19);
        if (w == 0) d = 0;
        else if (w == 1) d = $urandom_range(0, 65535);
        else d = $urandom_range(1, 6);
        return make_req(k, $urandom_range(0, 15),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 3), d);
    endfunction

    // response side: random stalls plus one long hold
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_response(out_data);
    end

    initial
    begin
        #500ms;
        $display("timeout after %0d requests", sent);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sb = new();
        sent = 0;
        long_hold = 0;
        sender_idle_on = 1;
        sink_idle_on = 1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_wdata = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: nothing ready, then each request and corner case
        write_slice(8'd2);
        send_req(make_req(pbts_pkg::REQ_SCHEDULE, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_TICK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_READY, 15, 31, 0));
        send_req(make_req(pbts_pkg::REQ_READY, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_READY, 3, 0, 0));
        send_req(make_req(pbts_pkg::REQ_READY, 3, 0, 0));
        send_req(make_req(pbts_pkg::REQ_SCHEDULE, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_TICK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_TICK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_UNREADY, 7, 0, 0));
        send_req(make_req(pbts_pkg::REQ_DELAY, 5, 0, 0));
        send_req(make_req(pbts_pkg::REQ_DELAY, 5, 0, 65535));
        send_req(make_req(pbts_pkg::REQ_DELAY, 6, 0, 1));
        send_req(make_req(pbts_pkg::REQ_DELAY, 5, 0, 1));
        send_req(make_req(pbts_pkg::REQ_WAKE, 9, 0, 0));
        send_req(make_req(pbts_pkg::REQ_DELAY, 9, 0, 3));
        send_req(make_req(pbts_pkg::REQ_WAKE, 9, 0, 0));
        send_req(make_req(pbts_pkg::REQ_TICK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_LOCK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_SCHEDULE, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_UNLOCK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_UNLOCK, 0, 0, 0));
        send_req(make_req(pbts_pkg::REQ_UNREADY, 6, 0, 0));
        wait_drained();

        // lock saturation
        write_slice(8'd0);
        repeat (260) send_req(make_req(pbts_pkg::REQ_LOCK, 0, 0, 0));
        repeat (256) send_req(make_req(pbts_pkg::REQ_UNLOCK, 0, 0, 0));
        wait_drained();

        // random phases across slice settings, with pressure phases
        for (int ph = 0; ph < 5; ph++)
        begin
            write_slice(ph == 0 ? 8'd1 : ph == 1 ? 8'd255 : ph == 2 ? 8'd3
                        : ph == 3 ? 8'd0 : 8'd10);
            if (ph == 1) long_hold = 1;
            if (ph == 4)
            begin
                sender_idle_on = 0;
                sink_idle_on = 0;
            end
            repeat (75)
            begin
                send_req(rand_req());
                if ($urandom_range(0, 199) == 0)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending_rsp.size() != 0) @(posedge clk);
                end
            end
            wait_drained();
        end

        $display("requests sent %0d, responses checked %0d", sent, sb.checked);
        $display("switches seen %0d, tasks woken %0d", sb.switches, sb.wakes);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d responses missing", sb.errors,
                     sb.pending_rsp.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/pbts_pkg.sv
hdl/pbts_ram.sv
hdl/priority_bitmap_task_scheduler.sv
verif/priority_bitmap_task_scheduler_tb.sv
